>>> sv/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list package
// Shared field widths, command and status codes, parameter defaults and the
// control structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

    // Fixed widths of the channel fields.
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Defaults for the top-level parameters.
    localparam int PAL_CAPACITY    = 16;
    localparam int PAL_ENTRY_WIDTH = 32;

    // Command codes.
    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_DESTROY  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd3;
    localparam logic [OP_W-1:0] OP_REPLACE  = 3'd4;
    localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd5;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_INIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;  // run the accepted command and load the result register
        logic step;  // load the next traverse entry into the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trav_more;  // the command being accepted is a traverse of 2+ entries
        logic trav_last;  // the traverse step now due emits the final entry
    } t_sts;

endpackage

>>> sv/pal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list controller
// Handshake control for both channels and the traverse sequencing state.
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pal_pkg::t_sts i_sts,
    output pal_pkg::t_cmd o_cmd
);
    import pal_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TRAV = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_free;
    t_cmd w_cmd;

    // The result register can take a new beat when empty or being drained.
    assign w_free     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_free;
    assign w_cmd.exec = i_in_valid && o_in_ready;
    assign w_cmd.step = (r_state == S_TRAV) && w_free;
    assign o_cmd      = w_cmd;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_cmd.exec && i_sts.trav_more) begin
                    n_state = S_TRAV;
                end
            end
            S_TRAV: begin
                if (w_cmd.step && i_sts.trav_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.exec || w_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/pal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list datapath
// Entry cells with parallel shift, count and init state, command checks and
// the registered result beat.
// ----------------------------------------------------------------------------
module pal_dp #(
    parameter int CAPACITY    = pal_pkg::PAL_CAPACITY,
    parameter int ENTRY_WIDTH = pal_pkg::PAL_ENTRY_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pal_pkg::t_cmd                 i_cmd,
    output pal_pkg::t_sts                 o_sts,
    input  logic [pal_pkg::OP_W-1:0]      i_operation,
    input  logic [pal_pkg::POS_W-1:0]     i_position,
    input  logic [pal_pkg::DATA_W-1:0]    i_entry_data,
    output logic [pal_pkg::STATUS_W-1:0]  o_status,
    output logic [pal_pkg::DATA_W-1:0]    o_entry_out,
    output logic                          o_entry_valid,
    output logic [pal_pkg::COUNT_W-1:0]   o_item_count,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic                          o_last
);
    import pal_pkg::*;

    localparam int EW = ENTRY_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [EW-1:0]       r_cell [CAPACITY];
    logic [EW-1:0]       n_cell [CAPACITY];
    logic [EW-1:0]       w_up   [CAPACITY];
    logic [EW-1:0]       w_dn   [CAPACITY];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_init;
    logic                n_init;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       n_idx;
    logic [STATUS_W-1:0] r_o_status;
    logic [STATUS_W-1:0] n_o_status;
    logic [EW-1:0]       r_o_entry;
    logic [EW-1:0]       n_o_entry;
    logic                r_o_ev;
    logic                n_o_ev;
    logic                r_o_last;
    logic                n_o_last;
    logic [CW-1:0]       r_o_count;
    logic [CW-1:0]       n_o_count;

    logic [PW-1:0]       w_pos;
    logic [PW-1:0]       w_cnt;
    logic [EW-1:0]       w_data;
    logic [IW-1:0]       w_rd_addr;
    logic [EW-1:0]       w_rd_data;
    logic                w_full;
    logic                w_do_ins;
    logic                w_do_del;
    logic                w_do_rep;

    assign w_pos  = PW'(i_position);
    assign w_cnt  = PW'(r_count);
    assign w_data = EW'(i_entry_data);
    assign w_full = (r_count == CW'(CAPACITY));

    // A new traverse reads the head; other commands read at the position;
    // traverse steps read at the running index.
    always_comb begin
        if (i_cmd.exec) begin
            w_rd_addr = (i_operation == OP_TRAVERSE) ? '0 : IW'(w_pos);
        end else begin
            w_rd_addr = r_idx;
        end
    end
    assign w_rd_data = r_cell[w_rd_addr];

    assign o_sts.trav_more = (i_operation == OP_TRAVERSE) && r_init
                             && (r_count > CW'(1));
    assign o_sts.trav_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // Neighbor values feeding each cell for shift up and shift down.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
        if (g == 0) begin : g_head
            assign w_up[g] = r_cell[g];
        end else begin : g_body
            assign w_up[g] = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_dn[g] = r_cell[g];
        end else begin : g_rest
            assign w_dn[g] = r_cell[g+1];
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (w_do_ins) begin
                if (PW'(i) == w_pos) begin
                    n_cell[i] = w_data;
                end else if (PW'(i) > w_pos) begin
                    n_cell[i] = w_up[i];
                end
            end else if (w_do_del) begin
                if (PW'(i) >= w_pos) begin
                    n_cell[i] = w_dn[i];
                end
            end else if (w_do_rep) begin
                if (PW'(i) == w_pos) begin
                    n_cell[i] = w_data;
                end
            end
        end
    end

    // Command checks and result formation.
    always_comb begin
        n_count    = r_count;
        n_init     = r_init;
        n_idx      = r_idx;
        n_o_status = r_o_status;
        n_o_entry  = r_o_entry;
        n_o_ev     = r_o_ev;
        n_o_last   = r_o_last;
        n_o_count  = r_o_count;
        w_do_ins   = 1'b0;
        w_do_del   = 1'b0;
        w_do_rep   = 1'b0;
        if (i_cmd.exec) begin
            n_o_status = ST_OK;
            n_o_entry  = '0;
            n_o_ev     = 1'b0;
            n_o_last   = 1'b1;
            unique case (i_operation)
                OP_CREATE: begin
                    n_init  = 1'b1;
                    n_count = '0;
                end
                OP_DESTROY: begin
                    n_init  = 1'b0;
                    n_count = '0;
                end
                OP_INSERT: begin
                    if (!r_init) begin
                        n_o_status = ST_NOT_INIT;
                    end else if (w_full) begin
                        n_o_status = ST_FULL;
                    end else if (w_pos > w_cnt) begin
                        n_o_status = ST_BAD_POS;
                    end else begin
                        w_do_ins = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                OP_DELETE: begin
                    if (!r_init) begin
                        n_o_status = ST_NOT_INIT;
                    end else if (w_pos >= w_cnt) begin
                        n_o_status = ST_BAD_POS;
                    end else begin
                        w_do_del  = 1'b1;
                        n_count   = r_count - CW'(1);
                        n_o_entry = w_rd_data;
                        n_o_ev    = 1'b1;
                    end
                end
                OP_REPLACE: begin
                    if (!r_init) begin
                        n_o_status = ST_NOT_INIT;
                    end else if (w_pos >= w_cnt) begin
                        n_o_status = ST_BAD_POS;
                    end else begin
                        w_do_rep = 1'b1;
                    end
                end
                OP_RETRIEVE: begin
                    if (!r_init) begin
                        n_o_status = ST_NOT_INIT;
                    end else if (w_pos >= w_cnt) begin
                        n_o_status = ST_BAD_POS;
                    end else begin
                        n_o_entry = w_rd_data;
                        n_o_ev    = 1'b1;
                    end
                end
                OP_TRAVERSE: begin
                    if (!r_init) begin
                        n_o_status = ST_NOT_INIT;
                    end else if (r_count != '0) begin
                        n_o_entry = w_rd_data;
                        n_o_ev    = 1'b1;
                        n_o_last  = (r_count == CW'(1));
                        n_idx     = IW'(1);
                    end
                end
                default: begin
                    // Unused code: plain OK beat, nothing changes.
                end
            endcase
            n_o_count = n_count;
        end else if (i_cmd.step) begin
            n_o_status = ST_OK;
            n_o_entry  = w_rd_data;
            n_o_ev     = 1'b1;
            n_o_last   = o_sts.trav_last;
            n_idx      = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_init  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_init  <= n_init;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell     <= n_cell;
        r_o_status <= n_o_status;
        r_o_entry  <= n_o_entry;
        r_o_ev     <= n_o_ev;
        r_o_last   <= n_o_last;
        r_o_count  <= n_o_count;
    end

    assign o_status      = r_o_status;
    assign o_entry_out   = DATA_W'(r_o_entry);
    assign o_entry_valid = r_o_ev;
    assign o_item_count  = COUNT_W'(r_o_count);
    assign o_is_empty    = (r_o_count == '0);
    assign o_is_full     = (r_o_count == CW'(CAPACITY));
    assign o_last        = r_o_last;

endmodule

>>> sv/positional_array_list.sv
`timescale 1ns / 1ps
// A result beat is in the output register in the cycle after its command is accepted. Throughput:
// one command per cycle unless stalled or mid-traverse; a traverse of N entries emits N beats,
// one a cycle unless stalled. The entry cells, the traverse index and the one-entry result
// register set that rate. The next command is taken in the cycle the final beat of the previous
// one is taken. Reset (synchronous, active low) clears count, init flag and handshake state at once.
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of up to CAPACITY entries with insert, delete, replace,
// retrieve and traverse commands; every result beat reports status and count.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int CAPACITY    = pal_pkg::PAL_CAPACITY,
    parameter int ENTRY_WIDTH = pal_pkg::PAL_ENTRY_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pal_pkg::OP_W-1:0]      i_operation,
    input  logic [pal_pkg::POS_W-1:0]     i_position,
    input  logic [pal_pkg::DATA_W-1:0]    i_entry_data,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pal_pkg::STATUS_W-1:0]  o_status,
    output logic [pal_pkg::DATA_W-1:0]    o_entry_out,
    output logic                          o_entry_valid,
    output logic [pal_pkg::COUNT_W-1:0]   o_item_count,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic                          o_last
);
    import pal_pkg::*;

    // The controller owns the handshakes and the traverse sequencing; the
    // datapath owns the entry cells, which shift a whole row in parallel on
    // insert or delete, and the result register.
    t_cmd w_cmd;
    t_sts w_sts;

    pal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pal_dp #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_entry_data  (i_entry_data),
        .o_status      (o_status),
        .o_entry_out   (o_entry_out),
        .o_entry_valid (o_entry_valid),
        .o_item_count  (o_item_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // An accepted command always has a beat waiting in the next cycle.
    a_cmd_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted command produced no result beat");

    // No new command is taken while a traverse still has beats to send.
    a_no_accept_mid_trav: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("command accepted in the middle of a traverse");

    // An error beat is always a single beat without an entry.
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_last && !o_entry_valid))
        else $error("error result carries an entry or is not final");

    // A beat without an entry shows a zero entry field.
    a_empty_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_entry_valid) |-> (o_entry_out == '0))
        else $error("entry field not zero on a beat without an entry");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives list commands through the valid/ready command channel and checks
// every result beat against a behavioral copy of the list kept in the bench.
// Directed tests cover the uninitialized list and the basic edits. Random
// sessions then fill, drain and edit the list with random contents.
// ----------------------------------------------------------------------------
module tb;
    import pal_pkg::*;

    localparam int LIST_CAP = PAL_CAPACITY;

    // Code 7 is not a command. The block answers it with a plain OK beat.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // One expected result beat, with fields in the order of the result ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   entry;
        logic                entry_valid;
        logic [COUNT_W-1:0]  count;
        logic                empty;
        logic                full;
        logic                last;
    } t_list_result;

    // Every input starts at a known value, with reset asserted.
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic [OP_W-1:0]     i_operation  = '0;
    logic [POS_W-1:0]    i_position   = '0;
    logic [DATA_W-1:0]   i_entry_data = '0;
    logic                i_out_ready  = 1'b0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_entry_out;
    logic                o_entry_valid;
    logic [COUNT_W-1:0]  o_item_count;
    logic                o_is_empty;
    logic                o_is_full;
    logic                o_last;

    // The bench's own copy of the list. It is updated when a command beat is
    // accepted, so it always describes the list that the next command will see.
    logic [DATA_W-1:0]   list_cells [LIST_CAP];
    int                  list_len  = 0;
    logic                list_live = 1'b0;

    // Result beats that are predicted but not yet seen, oldest first.
    t_list_result        pending_results [$];
    int                  mismatches = 0;

    // While this is set, neither side inserts idle cycles.
    logic                steady_flow = 1'b0;

    positional_array_list DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_entry_data (i_entry_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_entry_out  (o_entry_out),
        .o_entry_valid(o_entry_valid),
        .o_item_count (o_item_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_last       (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Records one predicted beat. The count, empty and full flags describe the
    // list after the command, so the caller updates the list model first.
    function automatic void queue_result(input logic [STATUS_W-1:0] st,
                                         input logic [DATA_W-1:0] val,
                                         input logic vld, input logic fin);
        t_list_result r;
        r.status      = st;
        r.entry       = vld ? val : '0;
        r.entry_valid = vld;
        r.count       = COUNT_W'(list_len);
        r.empty       = (list_len == 0);
        r.full        = (list_len >= LIST_CAP);
        r.last        = fin;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted command to the list model and queues its beats.
    // Create, destroy and the unused code work whether or not the list is
    // initialized. The other commands are refused until a create. An insert
    // into a full list fails on capacity before its position is looked at.
    function automatic void apply_list_command(input logic [OP_W-1:0] op,
                                               input logic [POS_W-1:0] pos,
                                               input logic [DATA_W-1:0] data);
        int k;
        if (op == OP_CREATE) begin
            list_live = 1'b1;
            list_len  = 0;
            queue_result(ST_OK, '0, 1'b0, 1'b1);
        end else if (op == OP_DESTROY) begin
            list_live = 1'b0;
            list_len  = 0;
            queue_result(ST_OK, '0, 1'b0, 1'b1);
        end else if (op == OP_UNUSED) begin
            queue_result(ST_OK, '0, 1'b0, 1'b1);
        end else if (!list_live) begin
            queue_result(ST_NOT_INIT, '0, 1'b0, 1'b1);
        end else if (op == OP_INSERT) begin
            if (list_len >= LIST_CAP) begin
                queue_result(ST_FULL, '0, 1'b0, 1'b1);
            end else if (int'(pos) > list_len) begin
                queue_result(ST_BAD_POS, '0, 1'b0, 1'b1);
            end else begin
                for (k = list_len; k > int'(pos); k--)
                    list_cells[POS_W'(k)] = list_cells[POS_W'(k-1)];
                list_cells[pos] = data;
                list_len++;
                queue_result(ST_OK, '0, 1'b0, 1'b1);
            end
        end else if (op == OP_TRAVERSE) begin
            if (list_len == 0) begin
                queue_result(ST_OK, '0, 1'b0, 1'b1);
            end else begin
                for (k = 0; k < list_len; k++)
                    queue_result(ST_OK, list_cells[POS_W'(k)], 1'b1, k + 1 == list_len);
            end
        end else if (int'(pos) >= list_len) begin
            // Delete, replace and retrieve need an existing entry.
            queue_result(ST_BAD_POS, '0, 1'b0, 1'b1);
        end else if (op == OP_DELETE) begin
            data = list_cells[pos];
            for (k = int'(pos); k + 1 < list_len; k++)
                list_cells[POS_W'(k)] = list_cells[POS_W'(k+1)];
            list_len--;
            queue_result(ST_OK, data, 1'b1, 1'b1);
        end else if (op == OP_REPLACE) begin
            list_cells[pos] = data;
            queue_result(ST_OK, '0, 1'b0, 1'b1);
        end else begin
            queue_result(ST_OK, list_cells[pos], 1'b1, 1'b1);
        end
    endfunction

    // Presents one command beat and returns at the edge where it is accepted.
    // Idle cycles may come first. Valid is left high so that the next command
    // can follow back to back. The caller must be at a rising edge.
    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] data);
        while (!steady_flow && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_position   <= pos;
        i_entry_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
        apply_list_command(op, pos, data);
    endtask

    // The result side stalls at random, except in the steady stretch.
    always @(posedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(0, 99) >= 22);
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Each accepted result beat is compared with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, status %0h entry %0h",
                         $time, o_status, o_entry_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", DATA_W'(want.status), DATA_W'(o_status));
                check_field("entry_out", want.entry, o_entry_out);
                check_field("entry_valid", DATA_W'(want.entry_valid),
                            DATA_W'(o_entry_valid));
                check_field("item_count", DATA_W'(want.count), DATA_W'(o_item_count));
                check_field("is_empty", DATA_W'(want.empty), DATA_W'(o_is_empty));
                check_field("is_full", DATA_W'(want.full), DATA_W'(o_is_full));
                check_field("last", DATA_W'(want.last), DATA_W'(o_last));
            end
        end
    end

    // Before any create, every list command must be refused with NOT_INIT.
    // The unused code and destroy still answer OK.
    task automatic test_before_create();
        send_command(OP_INSERT, 4'd0, 32'h1234_5678);
        send_command(OP_DELETE, 4'd0, '0);
        send_command(OP_REPLACE, 4'd0, 32'hFFFF_FFFF);
        send_command(OP_RETRIEVE, 4'd15, '0);
        send_command(OP_TRAVERSE, 4'd0, '0);
        send_command(OP_UNUSED, 4'd15, 32'hFFFF_FFFF);
        send_command(OP_DESTROY, 4'd0, '0);
    endtask

    // Basic edits on a small list: an empty traverse, bad positions at both
    // ends, extreme data values, shifts on insert and delete, and a create
    // on a list that still holds entries.
    task automatic test_basic_edits();
        send_command(OP_CREATE, 4'd0, '0);
        send_command(OP_TRAVERSE, 4'd0, '0);
        send_command(OP_DELETE, 4'd0, '0);
        send_command(OP_INSERT, 4'd1, 32'hDEAD_BEEF);
        send_command(OP_INSERT, 4'd0, 32'h0000_0000);
        send_command(OP_INSERT, 4'd1, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 4'd1, 32'hA5A5_A5A5);
        send_command(OP_REPLACE, 4'd2, 32'h5A5A_5A5A);
        send_command(OP_REPLACE, 4'd3, 32'h0F0F_0F0F);
        send_command(OP_RETRIEVE, 4'd0, '0);
        send_command(OP_RETRIEVE, 4'd15, '0);
        send_command(OP_TRAVERSE, 4'd0, '0);
        send_command(OP_DELETE, 4'd0, '0);
        send_command(OP_DELETE, 4'd1, '0);
        send_command(OP_UNUSED, 4'd0, '0);
        send_command(OP_TRAVERSE, 4'd0, '0);
        send_command(OP_CREATE, 4'd0, '0);
        send_command(OP_TRAVERSE, 4'd0, '0);
    endtask

    // Random sessions. Most commands are well formed for the current list:
    // positions in range, with bursts that fill the list to capacity or drain
    // it to empty. The rest are random noise, and from time to time the list
    // is recreated or destroyed. A stretch in the middle runs without idling.
    task automatic test_random_sessions(input int n_items);
        int sent;
        int mode;
        int hi;
        logic [OP_W-1:0] op;
        sent = 0;
        while (sent < n_items) begin
            steady_flow = (sent >= n_items / 2) && (sent < n_items / 2 + 70);
            mode = $urandom_range(0, 19);
            if (!list_live && mode > 1) begin
                // Most of the time a dead list is brought back at once.
                send_command(OP_CREATE, POS_W'($urandom_range(0, 15)), $urandom);
                sent++;
            end else if (mode <= 1) begin
                send_command(OP_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 15)),
                             $urandom);
                sent++;
            end else if (mode == 2) begin
                send_command($urandom_range(0, 2) == 0 ? OP_DESTROY : OP_CREATE,
                             POS_W'($urandom_range(0, 15)), $urandom);
                sent++;
            end else if (mode <= 4) begin
                // Fill to capacity, then push once more against the full list.
                while (list_len < LIST_CAP) begin
                    send_command(OP_INSERT,
                                 POS_W'($urandom_range(0, list_len > 15 ? 15 : list_len)),
                                 $urandom);
                    sent++;
                end
                send_command(OP_INSERT, POS_W'($urandom_range(0, 15)), $urandom);
                send_command(OP_TRAVERSE, POS_W'($urandom_range(0, 15)), $urandom);
                sent += 2;
            end else if (mode == 5) begin
                // Drain to empty, then delete once more from the empty list.
                while (list_len > 0) begin
                    send_command(OP_DELETE, POS_W'($urandom_range(0, list_len - 1)),
                                 $urandom);
                    sent++;
                end
                send_command(OP_DELETE, POS_W'($urandom_range(0, 15)), $urandom);
                sent++;
            end else begin
                op = OP_W'(32'(OP_INSERT) + $urandom_range(0, 4));
                hi = (op == OP_INSERT) ? list_len : list_len - 1;
                if (hi > 15)
                    hi = 15;
                if (hi < 0 || $urandom_range(0, 7) == 0)
                    send_command(op, POS_W'($urandom_range(0, 15)), $urandom);
                else
                    send_command(op, POS_W'($urandom_range(0, hi)), $urandom);
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_before_create();
        test_basic_edits();
        test_random_sessions(400);
        i_in_valid <= 1'b0;
        // Let every predicted beat arrive, then watch a few more cycles for
        // any stray beat. The overall time limit bounds this wait.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Time limit: several times the slowest expected run.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
